// File: rtl/core/kn_pkg.sv
// kn_pkg: payload types, rotator lane type, arctangent table and fixed constants
// for the polarized Klein-Nishina cross-section pipeline.
// No dependencies.
package kn_pkg;

  typedef struct packed {
    logic        [23:0] energy_kev;
    logic signed [15:0] polar_angle;
    logic signed [15:0] azimuth_angle;
  } kn_in_t;

  typedef struct packed {
    logic [31:0] cross_section;
    logic        energy_error;
  } kn_out_t;

  // One CORDIC lane: Q30 vector, residual angle (2^32 = full turn), half-turn flag
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
  } kn_rot_t;

  localparam logic REG_REST   = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  localparam logic [23:0] REST_RESET   = 24'd130816;
  localparam logic [31:0] RADIUS_RESET = 32'd341053691;

  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [33:0] Q_ONE    = 34'sd1073741824;

  localparam int PROD_W = 55;  // omc * energy
  localparam int REST_W = 24;
  localparam int K0K_W  = 56;
  localparam int R_W    = 31;  // values up to 2^30

  function automatic logic [31:0] kn_atan(input int idx);
    logic [31:0] a;
    unique case (idx)
      0:  a = 32'h20000000;  1:  a = 32'h12E4051E;  2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;  4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;  8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;  10: a = 32'h000A2F98;  11: a = 32'h000517CC;
      12: a = 32'h00028BE6;  13: a = 32'h000145F3;  14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;  16: a = 32'h000028BE;  17: a = 32'h0000145F;
      18: a = 32'h00000A30;  19: a = 32'h00000518;  20: a = 32'h0000028C;
      21: a = 32'h00000146;  22: a = 32'h000000A3;  23: a = 32'h00000051;
      24: a = 32'h00000029;  25: a = 32'h00000014;  26: a = 32'h0000000A;
      27: a = 32'h00000005;  28: a = 32'h00000003;  29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Fold a 32-bit turn into [-pi/2, pi/2) and load the rotator start vector
  function automatic kn_rot_t kn_rot_init(input logic [31:0] ang);
    kn_rot_t     r;
    logic        fl;
    logic [31:0] a2;
    fl     = ang[31] ^ ang[30];
    a2     = {ang[31] ^ fl, ang[30:0]};
    r.x    = GAIN_INV;
    r.y    = '0;
    r.z    = {a2[31], a2};
    r.flip = fl;
    return r;
  endfunction

  function automatic logic signed [33:0] kn_clamp(input logic signed [33:0] v);
    logic signed [33:0] c;
    if (v > Q_ONE) c = Q_ONE;
    else if (v < -Q_ONE) c = -Q_ONE;
    else c = v;
    return c;
  endfunction

endpackage

// File: rtl/core/klein_nishina_polarized_dcs.sv
// klein_nishina_polarized_dcs: polarized Klein-Nishina cross-section pipeline.
// Depends on kn_pkg, kn_cordic_cell, kn_div_cell.
//
//   port group  | dir | handshake              | payload
//   in_         | in  | in_valid / in_ready    | kn_in_t  (energy, polar, azimuth)
//   out_        | out | out_valid / out_ready  | kn_out_t (cross section, error flag)
//   APB         | in  | psel/penable/pready    | rest_energy @0, radius_squared @4
//
// One request per cycle unless the output stalls; requests pass the CORDIC cells,
// the 55 cells of the energy divider and the 31 cells of the reciprocal divider.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
// The whole row of cells advances whenever the output register is empty or taken;
// a stalled result holds every cell, and in_ready follows the same advance.
module klein_nishina_polarized_dcs import kn_pkg::*; #(
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  kn_in_t      in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output kn_out_t     out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NC = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;

  // ---------------- configuration ----------------
  logic [23:0] rest_r;
  logic [31:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r   <= REST_RESET;
      radius_r <= RADIUS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_REST:   rest_r   <= pwdata[23:0];
        REG_RADIUS: radius_r <= pwdata;
        default:    ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_REST:   prdata = {8'd0, rest_r};
      REG_RADIUS: prdata = radius_r;
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic    adv;
  logic    out_valid_r;
  kn_out_t out_data_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- angle fold ----------------
  logic [ANGLE_BITS-1:0] th_m, ph_m;
  logic [31:0]           th_turn, ph_turn;
  logic                  pre_v_r;
  kn_rot_t               pre_th_r, pre_ph_r;
  logic [23:0]           pre_e_r;

  assign th_m    = ANGLE_BITS'($unsigned(in_data.polar_angle));
  assign ph_m    = ANGLE_BITS'($unsigned(in_data.azimuth_angle));
  assign th_turn = {th_m, {(32-ANGLE_BITS){1'b0}}};
  assign ph_turn = {ph_m, {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (adv) begin
      pre_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_th_r <= kn_rot_init(th_turn);
      pre_ph_r <= kn_rot_init(ph_turn);
      pre_e_r  <= in_data.energy_kev;
    end
  end

  // ---------------- CORDIC row ----------------
  logic        c_v  [NC+1];
  kn_rot_t     c_th [NC+1];
  kn_rot_t     c_ph [NC+1];
  logic [23:0] c_e  [NC+1];

  assign c_v[0]  = pre_v_r;
  assign c_th[0] = pre_th_r;
  assign c_ph[0] = pre_ph_r;
  assign c_e[0]  = pre_e_r;

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    kn_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .v_i  (c_v[i]),
      .th_i (c_th[i]),
      .ph_i (c_ph[i]),
      .e_i  (c_e[i]),
      .v_o  (c_v[i+1]),
      .th_o (c_th[i+1]),
      .ph_o (c_ph[i+1]),
      .e_o  (c_e[i+1])
    );
  end

  // ---------------- unfold, clamp, 1 - cos ----------------
  logic signed [33:0] ct, st, cp, st_abs, cp_abs, omc_w;
  logic               p1_v_r, p1_err_r;
  logic [31:0]        p1_omc_r;
  logic [R_W-1:0]     p1_s_r, p1_c_r;
  logic [23:0]        p1_e_r;

  assign ct     = kn_clamp(c_th[NC].flip ? -c_th[NC].x : c_th[NC].x);
  assign st     = kn_clamp(c_th[NC].flip ? -c_th[NC].y : c_th[NC].y);
  assign cp     = kn_clamp(c_ph[NC].flip ? -c_ph[NC].x : c_ph[NC].x);
  assign st_abs = st[33] ? -st : st;
  assign cp_abs = cp[33] ? -cp : cp;
  assign omc_w  = Q_ONE - ct;

  // ---------------- products ----------------
  logic              p2_v_r, p2_err_r;
  logic [PROD_W-1:0] p2_prod_r;
  logic [R_W-1:0]    p2_s2_r, p2_c2_r;
  logic [61:0]       s_sq, c_sq, sc_prod;
  logic [R_W-1:0]    p_val;
  logic [23:0]       divisor;

  assign s_sq    = {31'd0, p1_s_r} * {31'd0, p1_s_r};
  assign c_sq    = {31'd0, p1_c_r} * {31'd0, p1_c_r};
  assign sc_prod = {31'd0, p2_s2_r} * {31'd0, p2_c2_r};
  assign p_val   = sc_prod[30+R_W-1:30];
  assign divisor = (rest_r == '0) ? 24'd1 : rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= c_v[NC];
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_omc_r  <= omc_w[31:0];
      p1_s_r    <= st_abs[R_W-1:0];
      p1_c_r    <= cp_abs[R_W-1:0];
      p1_e_r    <= c_e[NC];
      p1_err_r  <= (c_e[NC] == '0);
      p2_prod_r <= PROD_W'({24'd0, p1_omc_r} * {32'd0, p1_e_r});
      p2_s2_r   <= s_sq[30+R_W-1:30];
      p2_c2_r   <= c_sq[30+R_W-1:30];
      p2_err_r  <= p1_err_r;
    end
  end

  // ---------------- energy divider: omc * E / rest_energy ----------------
  logic              d1_v    [PROD_W+1];
  logic [REST_W-1:0] d1_rem  [PROD_W+1];
  logic [PROD_W-1:0] d1_nq   [PROD_W+1];
  logic [REST_W-1:0] d1_d    [PROD_W+1];
  logic [R_W:0]      d1_side [PROD_W+1];

  assign d1_v[0]    = p2_v_r;
  assign d1_rem[0]  = '0;
  assign d1_nq[0]   = p2_prod_r;
  assign d1_d[0]    = divisor;
  assign d1_side[0] = {p2_err_r, p_val};

  for (genvar i = 0; i < PROD_W; i++) begin : g_div1
    kn_div_cell #(.DW(REST_W), .QW(PROD_W), .SW(R_W+1)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .v_i   (d1_v[i]),
      .rem_i (d1_rem[i]),
      .nq_i  (d1_nq[i]),
      .d_i   (d1_d[i]),
      .side_i(d1_side[i]),
      .v_o   (d1_v[i+1]),
      .rem_o (d1_rem[i+1]),
      .nq_o  (d1_nq[i+1]),
      .d_o   (d1_d[i+1]),
      .side_o(d1_side[i+1])
    );
  end

  // ---------------- k0k ----------------
  logic             p4_v_r;
  logic [K0K_W-1:0] p4_k0k_r;
  logic [R_W:0]     p4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (adv) begin
      p4_v_r <= d1_v[PROD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_k0k_r  <= (K0K_W'(1) << 30) + {1'b0, d1_nq[PROD_W]};
      p4_side_r <= d1_side[PROD_W];
    end
  end

  // ---------------- reciprocal divider: 2^60 / k0k ----------------
  logic             d2_v    [R_W+1];
  logic [K0K_W-1:0] d2_rem  [R_W+1];
  logic [R_W-1:0]   d2_nq   [R_W+1];
  logic [K0K_W-1:0] d2_d    [R_W+1];
  logic [R_W:0]     d2_side [R_W+1];

  // Dividend bits above the quotient field reduce to 2^29; the rest are zero
  assign d2_v[0]    = p4_v_r;
  assign d2_rem[0]  = K0K_W'(1) << 29;
  assign d2_nq[0]   = '0;
  assign d2_d[0]    = p4_k0k_r;
  assign d2_side[0] = p4_side_r;

  for (genvar i = 0; i < R_W; i++) begin : g_div2
    kn_div_cell #(.DW(K0K_W), .QW(R_W), .SW(R_W+1)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .v_i   (d2_v[i]),
      .rem_i (d2_rem[i]),
      .nq_i  (d2_nq[i]),
      .d_i   (d2_d[i]),
      .side_i(d2_side[i]),
      .v_o   (d2_v[i+1]),
      .rem_o (d2_rem[i+1]),
      .nq_o  (d2_nq[i+1]),
      .d_o   (d2_d[i+1]),
      .side_o(d2_side[i+1])
    );
  end

  // ---------------- bracket ----------------
  logic           p5_v_r, p6_v_r, p7_v_r;
  logic           p5_err_r, p6_err_r, p7_err_r;
  logic [R_W-1:0] p5_r_r, p5_r2_r, p5_p_r, p6_r_r, p6_r3_r, p6_q_r;
  logic [31:0]    p7_f_r;
  logic [61:0]    rr, r2r, r2p;
  logic [32:0]    f_w;
  logic [63:0]    res_w;

  assign rr    = {31'd0, d2_nq[R_W]} * {31'd0, d2_nq[R_W]};
  assign r2r   = {31'd0, p5_r2_r} * {31'd0, p5_r_r};
  assign r2p   = {31'd0, p5_r2_r} * {31'd0, p5_p_r};
  assign f_w   = {2'b00, p6_r3_r} + {2'b00, p6_r_r} - {1'b0, p6_q_r, 1'b0};
  assign res_w = {32'd0, radius_r} * {32'd0, p7_f_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r      <= 1'b0;
      p6_v_r      <= 1'b0;
      p7_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p5_v_r      <= d2_v[R_W];
      p6_v_r      <= p5_v_r;
      p7_v_r      <= p6_v_r;
      out_valid_r <= p7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_r_r   <= d2_nq[R_W];
      p5_r2_r  <= rr[30+R_W-1:30];
      p5_p_r   <= d2_side[R_W][R_W-1:0];
      p5_err_r <= d2_side[R_W][R_W];
      p6_r_r   <= p5_r_r;
      p6_r3_r  <= r2r[30+R_W-1:30];
      p6_q_r   <= r2p[30+R_W-1:30];
      p6_err_r <= p5_err_r;
      // drop a negative bracket to zero
      p7_f_r   <= f_w[32] ? 32'd0 : f_w[31:0];
      p7_err_r <= p6_err_r;
      if (p7_err_r) begin
        out_data_r.cross_section <= '0;
      end else if (res_w[63:31] > 33'h0FFFFFFFF) begin
        out_data_r.cross_section <= 32'hFFFFFFFF;
      end else begin
        out_data_r.cross_section <= res_w[62:31];
      end
      out_data_r.energy_error <= p7_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/kn_cordic_cell.sv
// kn_cordic_cell: one CORDIC micro-rotation for the polar and azimuth lanes.
// Depends on kn_pkg (kn_rot_t, kn_atan).
module kn_cordic_cell import kn_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_i,
  input  kn_rot_t     th_i,
  input  kn_rot_t     ph_i,
  input  logic [23:0] e_i,
  output logic        v_o,
  output kn_rot_t     th_o,
  output kn_rot_t     ph_o,
  output logic [23:0] e_o
);

  localparam logic signed [32:0] ATAN = {1'b0, kn_atan(STAGE)};

  logic        v_r;
  kn_rot_t     th_r, th_nxt, ph_r, ph_nxt;
  logic [23:0] e_r;

  function automatic kn_rot_t rot_step(input kn_rot_t a);
    kn_rot_t            b;
    logic signed [33:0] dx, dy;
    dx = a.y >>> STAGE;
    dy = a.x >>> STAGE;
    b.flip = a.flip;
    if (!a.z[32]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - ATAN;
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + ATAN;
    end
    return b;
  endfunction

  assign th_nxt = rot_step(th_i);
  assign ph_nxt = rot_step(ph_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r <= th_nxt;
      ph_r <= ph_nxt;
      e_r  <= e_i;
    end
  end

  assign v_o  = v_r;
  assign th_o = th_r;
  assign ph_o = ph_r;
  assign e_o  = e_r;

endmodule

// File: rtl/core/kn_div_cell.sv
// kn_div_cell: one restoring-division step; produces one quotient bit.
// Partial remainder, dividend/quotient shift word, divisor and sideband travel along.
module kn_div_cell #(
  parameter int DW = 24,
  parameter int QW = 55,
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] nq_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] nq_o,
  output logic [DW-1:0] d_o,
  output logic [SW-1:0] side_o
);

  logic          v_r;
  logic [DW-1:0] rem_r, rem_nxt, d_r;
  logic [QW-1:0] nq_r, nq_nxt;
  logic [SW-1:0] side_r;
  logic [DW:0]   trial, diff;
  logic          ge;

  // Bring down the next dividend bit, subtract if it fits
  assign trial   = {rem_i, nq_i[QW-1]};
  assign ge      = trial >= {1'b0, d_i};
  assign diff    = trial - {1'b0, d_i};
  assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign nq_nxt  = {nq_i[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

// File: tb/klein_nishina_polarized_dcs_tb.sv
// klein_nishina_polarized_dcs_tb: self-checking bench for the polarized Klein-Nishina
// cross-section pipeline; predicts every result in fixed point and compares in order.
// Depends on kn_pkg and klein_nishina_polarized_dcs.
`timescale 1ns / 1ps

module klein_nishina_polarized_dcs_tb;
  import kn_pkg::*;

  localparam int TURN_STAGES = 18;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] ADDR_REST = 3'd0;
  localparam logic [2:0] ADDR_RADIUS = 3'd4;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  kn_in_t in_data;
  logic out_valid;
  logic out_ready;
  kn_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  klein_nishina_polarized_dcs i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [31:0] atan_turn [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  logic [23:0] rest_cfg;
  logic [31:0] radius_cfg;

  kn_in_t pending_requests[$];
  kn_out_t expected_dcs[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int zero_energy_seen = 0;
  int cycles = 0;

  logic in_fire;
  logic out_fire;
  int in_gap;
  int out_wait;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cos and sin of a binary angle in Q30
  function automatic void rotate_angle(input logic [15:0] a, output longint co,
                                       output longint si);
    logic [31:0] t;
    logic flip;
    longint x, y, z, dx, dy;
    t = {a, 16'h0000};
    flip = t[31] ^ t[30];
    if (flip) t = t - 32'h80000000;
    z = longint'(signed'(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TURN_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_turn[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_turn[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    co = (x > 64'sd1073741824) ? 64'sd1073741824 : (x < -64'sd1073741824) ? -64'sd1073741824 : x;
    si = (y > 64'sd1073741824) ? 64'sd1073741824 : (y < -64'sd1073741824) ? -64'sd1073741824 : y;
  endfunction

  function automatic kn_out_t cross_section_of(input kn_in_t req);
    kn_out_t res;
    logic [63:0] e, omc, dv, k0k, r, r2, r3, s2, c2, p, q, prod, ms, mc;
    longint ct, st, cp, sp, f;
    res.cross_section = '0;
    res.energy_error = 1'b1;
    e = 64'(req.energy_kev);
    if (e != 0) begin
      rotate_angle(req.polar_angle, ct, st);
      rotate_angle(req.azimuth_angle, cp, sp);
      omc = 64'(64'sd1073741824 - ct);
      dv = (rest_cfg != 0) ? 64'(rest_cfg) : 64'd1;
      k0k = 64'd1073741824 + (omc * e) / dv;
      r = (64'd1 << 60) / k0k;
      r2 = (r * r) >> 30;
      r3 = (r2 * r) >> 30;
      ms = 64'((st < 0) ? -st : st);
      mc = 64'((cp < 0) ? -cp : cp);
      s2 = (ms * ms) >> 30;
      c2 = (mc * mc) >> 30;
      p = (s2 * c2) >> 30;
      q = (r2 * p) >> 30;
      f = longint'(r3) + longint'(r) - 2 * longint'(q);
      if (f < 0) f = 0;
      prod = (64'(radius_cfg) * 64'(f)) >> 31;
      res.cross_section = (prod > 64'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0];
      res.energy_error = 1'b0;
    end
    return res;
  endfunction

  function automatic kn_in_t random_request();
    kn_in_t req;
    case ($urandom_range(0, 5))
      0: req.energy_kev = 24'($urandom);
      1: req.energy_kev = 24'($urandom_range(1, 4096));
      2: req.energy_kev = 24'($urandom_range(1, 400000));
      3: req.energy_kev = 24'hFFFFFF - 24'($urandom_range(0, 255));
      4: req.energy_kev = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom_range(1, 16));
      default: req.energy_kev = 24'($urandom_range(100000, 2000000));
    endcase
    req.polar_angle = 16'($urandom);
    req.azimuth_angle = 16'($urandom);
    return req;
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_REST) rest_cfg = value[23:0];
    else radius_cfg = value;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_dcs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: hold the request until taken, then idle a drawn number of cycles
  always @(negedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      burst_left <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_fire) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_requests.size() != 0) begin
          in_data <= pending_requests.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            in_gap <= 0;
            burst_left <= burst_left - 1;
          end else begin
            in_gap <= $urandom_range(0, 17);
            if ($urandom_range(0, 60) == 0) burst_left <= $urandom_range(20, 80);
          end
        end
      end
      in_valid <= nv;
    end
  end

  // hold ready low for the drawn number of cycles after each taken result
  always @(negedge clk) begin
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (out_valid && out_fire) begin
      draw = (burst_left > 0) ? 0 : $urandom_range(0, 17);
      if (draw == 0) begin
        out_wait <= 0;
        out_ready <= 1'b1;
      end else begin
        out_wait <= draw - 1;
        out_ready <= 1'b0;
      end
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    kn_out_t want;
    cycles <= cycles + 1;
    in_fire <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_dcs.push_back(cross_section_of(in_data));
        accepted++;
        if (in_data.energy_kev == 0) zero_energy_seen++;
      end
      if (out_valid && out_ready) begin
        if (expected_dcs.size() == 0) begin
          $display("%0t: unexpected result: cross_section %0d error %0b", $time,
                   out_data.cross_section, out_data.energy_error);
          errors++;
        end else begin
          want = expected_dcs.pop_front();
          checked++;
          if (want.cross_section !== out_data.cross_section)begin
            $display("%0t: cross_section expected %0d actual %0d", $time,
                     want.cross_section, out_data.cross_section);
            errors++;
          end
          if (want.energy_error !== out_data.energy_error) begin
            $display("%0t: energy_error expected %0b actual %0b", $time,
                     want.energy_error, out_data.energy_error);
            errors++;
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("klein_nishina_polarized_dcs: mismatch");
      $finish;
    end
  end

  initial begin
    logic [23:0] rest_set [0:5];
    logic [31:0] radius_set [0:5];
    logic [15:0] angles [0:6];
    kn_in_t req;
    rest_set = '{REST_RESET, 24'd1, 24'hFFFFFF, 24'd0, 24'd511, REST_RESET};
    radius_set = '{RADIUS_RESET, 32'hFFFFFFFF, 32'd0, 32'd1, 32'h9E3779B9, RADIUS_RESET};
    angles = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h3FFF, 16'h0001};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_fire = 1'b0; out_fire = 1'b0;
    rest_cfg = REST_RESET;
    radius_cfg = RADIUS_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        wait_idle();
        write_reg(ADDR_REST, 32'(rest_set[ph]));
        write_reg(ADDR_RADIUS, radius_set[ph]);
      end
      // extreme and random energies against the quadrant edges of both angles
      for (int i = 0; i < 7; i++) begin
        req.energy_kev = (i == 0) ? 24'd0 : (i == 1) ? 24'd1 : (i == 2) ? 24'hFFFFFF
                       : 24'($urandom_range(1, 24'hFFFFFF));
        req.polar_angle = angles[i];
        req.azimuth_angle = angles[6 - i];
        pending_requests.push_back(req);
        req.polar_angle = angles[(i + 3) % 7];
        req.azimuth_angle = angles[i];
        pending_requests.push_back(req);
      end
      for (int n = 0; n < 205; n++) pending_requests.push_back(random_request());
    end
    wait_idle();

    $display("%0d requests in 6 register settings (%0d with zero energy), %0d results checked",
             accepted, zero_energy_seen, checked);
    if (errors == 0) begin
      $display("klein_nishina_polarized_dcs: match");
    end else begin
      $display("klein_nishina_polarized_dcs: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/kn_pkg.sv
rtl/core/kn_cordic_cell.sv
rtl/core/kn_div_cell.sv
rtl/core/klein_nishina_polarized_dcs.sv
tb/klein_nishina_polarized_dcs_tb.sv
